>>> hw/rtl/lr_pkg.sv
package lr_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int FRAC_W      = 16;
  localparam int POS_W       = 21;
  localparam int STEP_W      = 21;
  localparam int PROD_W      = SAMPLE_W + FRAC_W + 2;
  localparam int TAIL_W      = POS_W + 2;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS) + 1;

  localparam logic [POS_W-1:0]  ONE_POS    = POS_W'(1) << FRAC_W;
  localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(ONE_POS >> 3);
  localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(ONE_POS) << 4;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(ONE_POS);
  localparam logic [TAIL_W-1:0] TAIL_LIM   = TAIL_W'(ONE_POS) << 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT
  } lr_state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;
    logic                       end_out;
  } out_beat_t;

endpackage

>>> hw/rtl/lr_lerp.sv
module lr_lerp import lr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       mul_en_i,
  input  logic signed [SAMPLE_W:0]   diff_i,
  input  logic        [FRAC_W-1:0]   frac_i,
  input  logic signed [SAMPLE_W-1:0] base_i,
  output logic signed [SAMPLE_W-1:0] result_o
);

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_W - 1);

  logic signed [PROD_W-1:0]        prod_d, prod_q;
  logic signed [PROD_W-1:0]        rnd;
  logic signed [PROD_W-FRAC_W-1:0] ofs;
  logic signed [PROD_W-FRAC_W-1:0] sum;

  assign prod_d = PROD_W'(diff_i) * PROD_W'($signed({1'b0, frac_i}));

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  assign rnd      = prod_q + HALF;
  assign ofs      = rnd[PROD_W-1:FRAC_W];
  assign sum      = ofs + (PROD_W-FRAC_W)'(base_i);
  assign result_o = sum[SAMPLE_W-1:0];

endmodule

>>> hw/rtl/linear_resampler.sv
// Linear interpolation resampler, one shared multiply and round unit.
// After an item is taken, each of its results passes through the multiply state and then the
// emit state, which rounds and loads the output register; in_stall_o is high from the first
// multiply state until the last result is emitted, including any time a result waits on
// out_stall_i. An item causes up to 16 results; one with none leaves in_stall_o low.
// Reset (rst_ni low, asynchronous) clears the stream state, drops any pending output
// beat and sets the step back to 1.0.
module linear_resampler import lr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [STEP_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_beat_t          in_beat_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_beat_t         out_beat_o
);

  lr_state_e state_d, state_q;

  logic [STEP_W-1:0]          step_d, step_q;
  logic signed [SAMPLE_W-1:0] prev_d, prev_q;
  logic signed [SAMPLE_W-1:0] cur_d, cur_q;
  logic signed [SAMPLE_W:0]   diff_d, diff_q;
  logic [POS_W-1:0]           pos_d, pos_q;
  logic [CNT_W-1:0]           cnt_d, cnt_q;
  logic                       last_d, last_q;
  logic                       tail_d, tail_q;
  logic                       have_prev_d, have_prev_q;
  logic                       out_valid_d, out_valid_q;
  out_beat_t                  out_d, out_q;

  logic                       in_acc;
  logic                       out_free;
  logic [POS_W-1:0]           pos_n;
  logic [POS_W-1:0]           pos_wrap;
  logic                       pos_over;
  logic [POS_W-1:0]           pos_skip;
  logic [CNT_W-1:0]           cnt_n;
  logic                       cnt_ok;
  logic                       interp_more;
  logic                       tail_fit_n;
  logic                       tail_fit_wrap;
  logic                       tail_fit_zero;
  logic                       tail_fit_skip;
  logic                       more;
  logic signed [SAMPLE_W-1:0] lerp_res;

  function automatic logic tail_fits(input logic [POS_W-1:0] p, input logic [STEP_W-1:0] s);
    logic [TAIL_W-1:0] lhs;
    lhs = {1'b0, p, 1'b0} + TAIL_W'(s);
    return lhs <= TAIL_LIM;
  endfunction

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign pos_n         = pos_q + POS_W'(step_q);
  assign pos_wrap      = (pos_n >= ONE_POS) ? (pos_n - ONE_POS) : '0;
  assign pos_over      = pos_q >= ONE_POS;
  assign pos_skip      = pos_q - ONE_POS;
  assign cnt_n         = cnt_q + CNT_W'(1);
  assign cnt_ok        = cnt_n < CNT_W'(MAX_RESULTS);
  assign interp_more   = (pos_n < ONE_POS) && cnt_ok;
  assign tail_fit_n    = tail_fits(pos_n, step_q);
  assign tail_fit_wrap = tail_fits(pos_wrap, step_q);
  assign tail_fit_zero = tail_fits('0, step_q);
  assign tail_fit_skip = tail_fits(pos_skip, step_q);
  assign more          = tail_q ? (tail_fit_n && cnt_ok)
                                : (interp_more || (last_q && tail_fit_wrap && cnt_ok));

  lr_lerp u_lerp (
    .clk_i    (clk_i),
    .mul_en_i (state_q == ST_MUL),
    .diff_i   (diff_q),
    .frac_i   (pos_q[FRAC_W-1:0]),
    .base_i   (prev_q),
    .result_o (lerp_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (have_prev_q) begin
            if (!pos_over || (in_beat_i.last_in && tail_fit_skip)) begin
              state_d = ST_MUL;
            end
          end else if (in_beat_i.last_in && tail_fit_zero) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = more ? ST_MUL : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    step_d      = step_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    diff_d      = diff_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    tail_d      = tail_q;
    have_prev_d = have_prev_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (cfg_we_i) begin
      if (cfg_data_i < STEP_MIN) begin
        step_d = STEP_MIN;
      end else if (cfg_data_i > STEP_MAX) begin
        step_d = STEP_MAX;
      end else begin
        step_d = cfg_data_i;
      end
    end

    if (in_acc) begin
      cur_d  = in_beat_i.sample_in;
      last_d = in_beat_i.last_in;
      cnt_d  = '0;
      if (have_prev_q) begin
        if (!pos_over) begin
          diff_d = (SAMPLE_W+1)'(in_beat_i.sample_in) - (SAMPLE_W+1)'(prev_q);
          tail_d = 1'b0;
        end else begin
          // no output falls in this interval: advance, and on a last item go straight to the tail
          prev_d = in_beat_i.sample_in;
          pos_d  = pos_skip;
          diff_d = '0;
          tail_d = 1'b1;
          if (in_beat_i.last_in && !tail_fit_skip) begin
            prev_d      = '0;
            pos_d       = '0;
            have_prev_d = 1'b0;
          end
        end
      end else begin
        prev_d = in_beat_i.sample_in;
        pos_d  = '0;
        diff_d = '0;
        tail_d = 1'b1;
        if (!in_beat_i.last_in) begin
          have_prev_d = 1'b1;
        end else if (!tail_fit_zero) begin
          prev_d = '0;
        end
      end
    end

    if ((state_q == ST_EMIT) && out_free) begin
      out_valid_d         = 1'b1;
      out_d.sample_out    = lerp_res;
      out_d.last_out      = !more;
      out_d.end_out       = !more && last_q;
      cnt_d               = cnt_n;
      if (tail_q) begin
        pos_d = pos_n;
        if (!more) begin
          prev_d      = '0;
          pos_d       = '0;
          have_prev_d = 1'b0;
        end
      end else if (interp_more) begin
        pos_d = pos_n;
      end else begin
        prev_d = cur_q;
        pos_d  = pos_wrap;
        if (last_q && tail_fit_wrap && cnt_ok) begin
          // switch to the tail: zero slope repeats the final sample
          tail_d = 1'b1;
          diff_d = '0;
        end else if (last_q) begin
          prev_d      = '0;
          pos_d       = '0;
          have_prev_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_RESET;
      prev_q      <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      tail_q      <= 1'b0;
      last_q      <= 1'b0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      prev_q      <= prev_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      tail_q      <= tail_d;
      last_q      <= last_d;
      have_prev_q <= have_prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    diff_q <= diff_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

>>> hw/rtl/lr_checker.sv
module lr_checker import lr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_beat_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("output beat dropped or changed under stall");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.end_out |-> out_beat_o.last_out)
    else $error("stream end beat not marked last");

  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output beat appeared while idle");

endmodule

bind linear_resampler lr_checker u_lr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);
